### sv/uitf_pkg.sv
package uitf_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W = 6;
  localparam int OP_W = 2;
  localparam int TMO_W = 8;
  localparam logic [TMO_W-1:0] IDLE_TIMEOUT_RESET = 8'd3;
  localparam logic [TMO_W-1:0] IDLE_MAX = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_RX_BYTE = 2'd0,
    OP_TICK    = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RXB,
    ST_TICK,
    ST_SEARCH,
    ST_NOTFOUND,
    ST_READ
  } state_t;

  typedef struct packed {
    logic capture;
    logic cfg_we;
    logic rx_exec;
    logic tick_exec;
    logic search;
    logic emit_none;
    logic issue_read;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic last_issue;
  } status_t;

endpackage

### sv/uart_rx_idle_timeout_framer_top.sv
// UART receive framer: cuts received bytes into frames on idle timeout and
// keeps them in a ring of SLOTS slots of FRAME_BYTES bytes each.
// Commands: start with operation (0 byte, 1 tick, 2 read) and rx_byte; taken
// at a clock edge where start is high and busy is low.
// A byte or a tick is accepted, then applied in its update state; operation
// 3 does nothing.
// A read is accepted, finds the lowest ready slot in the search state, then
// reads the frame through the frame RAM read port in the read state; beats
// appear on strobe in the cycle after each RAM read, one per cycle, last
// marking the final one. With no ready frame a single beat with found low
// and last high follows the search and not-found states.
// Results cannot be held off: each beat is valid for exactly one cycle.
// The idle timeout register is written on the cfg channel while not busy.
// Reset (rst, synchronous) empties all slots, sets the timeout to 3 and
// returns to idle; frame RAM contents are not cleared.
module uart_rx_idle_timeout_framer_top #(
  parameter int SLOTS = 4,
  parameter int FRAME_BYTES = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [uitf_pkg::OP_W-1:0]   operation,
  input  logic [uitf_pkg::DATA_W-1:0] rx_byte,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [uitf_pkg::TMO_W-1:0]  cfg_data,
  output logic                        strobe,
  output logic                        found,
  output logic [uitf_pkg::DATA_W-1:0] data_byte,
  output logic [uitf_pkg::LEN_W-1:0]  frame_length,
  output logic                        last
);
  import uitf_pkg::*;

  cmd_t    cmd;
  status_t status;

  uitf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operation(operation),
    .cfg_valid(cfg_valid),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .cfg_ready(cfg_ready)
  );

  uitf_datapath #(
    .SLOTS      (SLOTS),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .rx_byte     (rx_byte),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .found       (found),
    .data_byte   (data_byte),
    .frame_length(frame_length),
    .last        (last)
  );

endmodule

### sv/uitf_ram.sv
module uitf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/uitf_ctrl.sv
module uitf_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [uitf_pkg::OP_W-1:0] operation,
  input  logic                      cfg_valid,
  input  uitf_pkg::status_t         status,
  output uitf_pkg::cmd_t            cmd,
  output logic                      busy,
  output logic                      cfg_ready
);
  import uitf_pkg::*;

  state_t state, state_next;
  logic accept;

  assign busy = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(operation))
            OP_RX_BYTE: state_next = ST_RXB;
            OP_TICK:    state_next = ST_TICK;
            OP_READ:    state_next = ST_SEARCH;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_RXB:      state_next = ST_IDLE;
      ST_TICK:     state_next = ST_IDLE;
      ST_SEARCH:   state_next = status.hit ? ST_READ : ST_NOTFOUND;
      ST_NOTFOUND: state_next = ST_IDLE;
      ST_READ: begin
        if (status.last_issue) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.capture = accept;
    cmd.cfg_we = cfg_valid && cfg_ready;
    unique case (state)
      ST_IDLE:     ;
      ST_RXB:      cmd.rx_exec = 1'b1;
      ST_TICK:     cmd.tick_exec = 1'b1;
      ST_SEARCH:   cmd.search = 1'b1;
      ST_NOTFOUND: cmd.emit_none = 1'b1;
      ST_READ:     cmd.issue_read = 1'b1;
      default:     ;
    endcase
  end

endmodule

### sv/uitf_datapath.sv
module uitf_datapath #(
  parameter int SLOTS = 4,
  parameter int FRAME_BYTES = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  uitf_pkg::cmd_t               cmd,
  output uitf_pkg::status_t            status,
  input  logic [uitf_pkg::DATA_W-1:0]  rx_byte,
  input  logic [uitf_pkg::TMO_W-1:0]   cfg_data,
  output logic                         strobe,
  output logic                         found,
  output logic [uitf_pkg::DATA_W-1:0]  data_byte,
  output logic [uitf_pkg::LEN_W-1:0]   frame_length,
  output logic                         last
);
  import uitf_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int DEPTH = SLOTS * FRAME_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(FRAME_BYTES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  logic [TMO_W-1:0]  idle_timeout;
  logic [CNT_W-1:0]  slot_count [SLOTS];
  logic [SLOTS-1:0]  slot_ready;
  logic [SLOT_W-1:0] write_slot;
  logic              receiving;
  logic [TMO_W-1:0]  idle_count;
  logic [DATA_W-1:0] byte_hold;

  logic [SLOT_W-1:0] sel_slot;
  logic [CNT_W-1:0]  sel_count;
  logic [IDX_W-1:0]  rd_idx;

  logic [DATA_W-1:0] rdata;
  logic              ram_we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;

  logic [SLOT_W-1:0] ws_inc;
  logic [CNT_W-1:0]  ws_count;
  logic [TMO_W-1:0]  idle_inc;
  logic              srch_hit;
  logic [SLOT_W-1:0] srch_slot;
  logic [CNT_W-1:0]  srch_count;
  logic              issue_last;

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
    slot_base = ADDR_W'(s) * ADDR_W'(FRAME_BYTES);
  endfunction

  assign ws_inc = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  assign ws_count = slot_count[write_slot];
  assign idle_inc = (idle_count < IDLE_MAX) ? idle_count + 1'b1 : idle_count;

  // lowest ready slot that holds bytes
  always_comb begin
    srch_hit = 1'b0;
    srch_slot = '0;
    srch_count = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (slot_ready[s] && slot_count[s] != '0) begin
        srch_hit = 1'b1;
        srch_slot = SLOT_W'(s);
        srch_count = slot_count[s];
      end
    end
  end

  assign issue_last = (CNT_W'(rd_idx) + 1'b1) == sel_count;
  assign status.hit = srch_hit;
  assign status.last_issue = issue_last;

  // a full slot hands the byte to the next slot, which is empty when not ready
  always_comb begin
    ram_we = 1'b0;
    waddr = slot_base(write_slot) + ADDR_W'(ws_count);
    if (cmd.rx_exec && !slot_ready[write_slot]) begin
      if (ws_count < FULL) begin
        ram_we = 1'b1;
      end else if (!slot_ready[ws_inc]) begin
        ram_we = 1'b1;
        waddr = slot_base(ws_inc);
      end
    end
  end

  assign raddr = slot_base(sel_slot) + ADDR_W'(rd_idx);

  uitf_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(byte_hold),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_TIMEOUT_RESET;
      slot_ready <= '0;
      write_slot <= '0;
      receiving <= 1'b0;
      idle_count <= '0;
      rd_idx <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_count[s] <= '0;
      end
    end else begin
      if (cmd.cfg_we) begin
        idle_timeout <= cfg_data;
      end
      if (cmd.rx_exec) begin
        idle_count <= '0;
        receiving <= 1'b1;
        if (slot_ready[write_slot]) begin
          receiving <= 1'b0;
          write_slot <= ws_inc;
        end else if (ws_count < FULL) begin
          slot_count[write_slot] <= ws_count + 1'b1;
        end else begin
          slot_ready[write_slot] <= 1'b1;
          write_slot <= ws_inc;
          if (slot_ready[ws_inc]) begin
            receiving <= 1'b0;
          end else begin
            slot_count[ws_inc] <= CNT_W'(1);
          end
        end
      end
      if (cmd.tick_exec && receiving) begin
        if (idle_inc >= idle_timeout) begin
          receiving <= 1'b0;
          idle_count <= '0;
          if (ws_count != '0) begin
            slot_ready[write_slot] <= 1'b1;
            write_slot <= ws_inc;
          end
        end else begin
          idle_count <= idle_inc;
        end
      end
      if (cmd.search) begin
        rd_idx <= '0;
      end
      if (cmd.issue_read) begin
        rd_idx <= rd_idx + 1'b1;
        if (issue_last) begin
          slot_ready[sel_slot] <= 1'b0;
          slot_count[sel_slot] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_hold <= rx_byte;
    end
    if (cmd.search) begin
      sel_slot <= srch_slot;
      sel_count <= srch_count;
    end
  end

  // result beat follows in the cycle after the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.issue_read || cmd.emit_none;
    end
  end

  always_ff @(posedge clk) begin
    found <= cmd.issue_read;
    last <= cmd.emit_none || issue_last;
    frame_length <= cmd.issue_read ? LEN_W'(sel_count) : '0;
  end

  assign data_byte = found ? rdata : '0;

endmodule

### sim/tb_uart_rx_idle_timeout_framer_top.sv
`timescale 1ns / 1ps

module tb_uart_rx_idle_timeout_framer_top;
  import uitf_pkg::*;

  localparam int SLOTS = 4;
  localparam int FRAME_BYTES = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int DIR_ROWS = 24;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  frame_length;
    logic              last;
  } beat_t;

  typedef struct {
    op_t               op;
    logic [DATA_W-1:0] b;
    bit                typed;
    beat_t             want;
  } dir_row_t;

  localparam beat_t NOT_FOUND = '{1'b0, 8'h00, 6'd0, 1'b1};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   operation = '0;
  logic [DATA_W-1:0] rx_byte = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TMO_W-1:0]  cfg_data = '0;
  logic              strobe;
  logic              found;
  logic [DATA_W-1:0] data_byte;
  logic [LEN_W-1:0]  frame_length;
  logic              last;

  // frame store model
  logic [DATA_W-1:0] ram_m [SLOTS*FRAME_BYTES];
  int unsigned       cnt_m [SLOTS];
  bit                rdy_m [SLOTS];
  int unsigned       wslot_m;
  bit                open_m;
  logic [TMO_W-1:0]  idle_m;
  logic [TMO_W-1:0]  tmo_m;

  beat_t    model_out [$];
  beat_t    pending_beats [$];
  dir_row_t dir_tbl [DIR_ROWS];

  int  mismatches = 0;
  int  beats_seen = 0;
  int  cmds_sent = 0;
  int  cfg_writes = 0;
  int  stall_cycles = 0;
  bit  calm = 1'b0;

  uart_rx_idle_timeout_framer_top #(
    .SLOTS(SLOTS),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .rx_byte(rx_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .strobe(strobe),
    .found(found),
    .data_byte(data_byte),
    .frame_length(frame_length),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic store_rx(input logic [DATA_W-1:0] b);
    if (cnt_m[wslot_m] < FRAME_BYTES) begin
      ram_m[wslot_m*FRAME_BYTES + cnt_m[wslot_m]] = b;
      cnt_m[wslot_m]++;
    end
  endtask

  task automatic frame_model(input op_t op, input logic [DATA_W-1:0] b);
    int s;
    int n;
    s = SLOTS;
    case (op)
      OP_RX_BYTE: begin
        open_m = 1'b1;
        idle_m = '0;
        if (rdy_m[wslot_m]) begin
          // unread frame in the way: drop and skip ahead
          open_m = 1'b0;
          wslot_m = (wslot_m + 1) % SLOTS;
        end else if (cnt_m[wslot_m] < FRAME_BYTES) begin
          store_rx(b);
        end else begin
          rdy_m[wslot_m] = 1'b1;
          wslot_m = (wslot_m + 1) % SLOTS;
          if (rdy_m[wslot_m]) open_m = 1'b0;
          else store_rx(b);
        end
      end
      OP_TICK: begin
        if (open_m) begin
          if (idle_m != IDLE_MAX) idle_m++;
          if (idle_m >= tmo_m) begin
            if (cnt_m[wslot_m] != 0) begin
              rdy_m[wslot_m] = 1'b1;
              wslot_m = (wslot_m + 1) % SLOTS;
            end
            open_m = 1'b0;
            idle_m = '0;
          end
        end
      end
      OP_READ: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (rdy_m[i] && cnt_m[i] != 0) s = i;
        end
        if (s == SLOTS) begin
          model_out.push_back(NOT_FOUND);
        end else begin
          n = cnt_m[s];
          for (int i = 0; i < n; i++) begin
            model_out.push_back('{1'b1, ram_m[s*FRAME_BYTES + i], LEN_W'(n), i == n - 1});
          end
          rdy_m[s] = 1'b0;
          cnt_m[s] = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(input op_t op, input logic [DATA_W-1:0] b, input bit typed,
                          input beat_t want);
    if (!calm && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    rx_byte <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    frame_model(op, b);
    if (typed) pending_beats.push_back(want);
    else foreach (model_out[i]) pending_beats.push_back(model_out[i]);
    model_out.delete();
    cmds_sent++;
  endtask

  task automatic set_timeout(input logic [TMO_W-1:0] v);
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    // bytes and ticks leave no beat behind; let the last one retire
    repeat (8) @(posedge clk);
    if (!calm) repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tmo_m = v;
    cfg_writes++;
  endtask

  task automatic run_phase(input int budget);
    int done;
    int len;
    int pick;
    int gap;
    op_t op;
    done = 0;
    while (done < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed frame, mostly short, a few past the slot size
        pick = $urandom_range(0, 99);
        len = (pick < 75) ? $urandom_range(1, 6) :
              (pick < 90) ? $urandom_range(7, 29) : $urandom_range(30, 36);
        for (int i = 0; i < len; i++) begin
          send_cmd(OP_RX_BYTE, 8'($urandom), 1'b0, '0);
          done++;
          if (tmo_m > 1 && $urandom_range(0, 99) < 15) begin
            gap = $urandom_range(1, (tmo_m > 20) ? 20 : tmo_m - 1);
            repeat (gap) send_cmd(OP_TICK, 8'($urandom), 1'b0, '0);
            done += gap;
          end
        end
        // a long timeout closes a frame only while the budget allows it
        if (tmo_m <= 32 || (done + tmo_m <= budget && $urandom_range(0, 99) < 30)) begin
          gap = (tmo_m == 0) ? 1 : tmo_m;
          repeat (gap) send_cmd(OP_TICK, 8'($urandom), 1'b0, '0);
          done += gap;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          send_cmd(OP_READ, 8'($urandom), 1'b0, '0);
          done++;
        end
        if (pick < 10) begin
          send_cmd(OP_READ, 8'($urandom), 1'b0, '0);
          done++;
        end
      end else if (pick < 85) begin
        op = op_t'($urandom_range(0, 3));
        send_cmd(op, 8'($urandom), 1'b0, '0);
        if (op != OP_NONE) done++;
      end else begin
        send_cmd(OP_READ, 8'($urandom), 1'b0, '0);
        done++;
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    beat_t want;
    if (!rst && strobe) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing pending, data_byte", 32'(data_byte), 0);
      end else begin
        want = pending_beats.pop_front();
        if (found !== want.found)
          report_mismatch("found", 32'(found), 32'(want.found));
        if (data_byte !== want.data_byte)
          report_mismatch("data_byte", 32'(data_byte), 32'(want.data_byte));
        if (frame_length !== want.frame_length)
          report_mismatch("frame_length", 32'(frame_length), 32'(want.frame_length));
        if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
      end
      beats_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cnt_m[i] = 0;
      rdy_m[i] = 1'b0;
    end
    wslot_m = 0;
    open_m = 1'b0;
    idle_m = '0;
    tmo_m = IDLE_TIMEOUT_RESET;

    dir_tbl = '{
      '{OP_READ,    8'h00, 1'b1, NOT_FOUND},
      '{OP_NONE,    8'hA5, 1'b0, '0},
      '{OP_TICK,    8'h00, 1'b0, '0},
      '{OP_RX_BYTE, 8'hFF, 1'b0, '0},
      '{OP_TICK,    8'h00, 1'b0, '0},
      '{OP_TICK,    8'hFF, 1'b0, '0},
      '{OP_TICK,    8'h00, 1'b0, '0},
      '{OP_READ,    8'h00, 1'b1, '{1'b1, 8'hFF, 6'd1, 1'b1}},
      '{OP_READ,    8'hFF, 1'b1, NOT_FOUND},
      '{OP_RX_BYTE, 8'h00, 1'b0, '0},
      '{OP_RX_BYTE, 8'h80, 1'b0, '0},
      '{OP_TICK,    8'h00, 1'b0, '0},
      '{OP_RX_BYTE, 8'h7F, 1'b0, '0},
      '{OP_TICK,    8'h00, 1'b0, '0},
      '{OP_TICK,    8'h00, 1'b0, '0},
      '{OP_NONE,    8'hFF, 1'b0, '0},
      '{OP_TICK,    8'h00, 1'b0, '0},
      '{OP_READ,    8'h00, 1'b0, '0},
      '{OP_RX_BYTE, 8'h01, 1'b0, '0},
      '{OP_TICK,    8'h00, 1'b0, '0},
      '{OP_TICK,    8'h00, 1'b0, '0},
      '{OP_TICK,    8'h00, 1'b0, '0},
      '{OP_RX_BYTE, 8'hFE, 1'b0, '0},
      '{OP_READ,    8'h00, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of the timeout is exercised first
    foreach (dir_tbl[i]) send_cmd(dir_tbl[i].op, dir_tbl[i].b, dir_tbl[i].typed,
                                  dir_tbl[i].want);

    set_timeout(8'd1);
    run_phase(70);
    set_timeout(8'd0);
    run_phase(60);
    set_timeout(8'd255);
    run_phase(60);
    calm = 1'b1;
    set_timeout(8'($urandom_range(2, 9)));
    run_phase(90);
    calm = 1'b0;
    set_timeout(IDLE_TIMEOUT_RESET);
    run_phase(60);

    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Ran %0d commands and checked %0d read beats", cmds_sent, beats_seen);
    $display("Timeout register written %0d times, values 0, 1, 3 and 255 included",
             cfg_writes);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### uart_rx_idle_timeout_framer_top.f
sv/uitf_pkg.sv
sv/uitf_ram.sv
sv/uitf_ctrl.sv
sv/uitf_datapath.sv
sv/uart_rx_idle_timeout_framer_top.sv
sim/tb_uart_rx_idle_timeout_framer_top.sv
